[src/mbrtu_pkg.sv]
package mbrtu_pkg;

  localparam int unsigned MAX_FRAME_BYTES_DEF = 256;
  localparam int unsigned CNT_W               = 9;
  localparam int unsigned HDR_DEPTH           = 7;
  localparam int unsigned HDR_IDX_W           = $clog2(HDR_DEPTH);

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_SHORT = 2'd1;
  localparam logic [1:0] ERR_CRC   = 2'd2;
  localparam logic [1:0] ERR_LONG  = 2'd3;

  localparam logic [7:0] FC_EXC_MIN       = 8'h80;
  localparam logic [7:0] FC_READ_COILS    = 8'h01;
  localparam logic [7:0] FC_READ_DISCRETE = 8'h02;
  localparam logic [7:0] FC_READ_HOLDING  = 8'h03;
  localparam logic [7:0] FC_READ_INPUT    = 8'h04;
  localparam logic [7:0] FC_WRITE_COIL    = 8'h05;
  localparam logic [7:0] FC_WRITE_REG     = 8'h06;
  localparam logic [7:0] FC_WRITE_COILS   = 8'h0F;
  localparam logic [7:0] FC_WRITE_REGS    = 8'h10;

  typedef logic [HDR_DEPTH-1:0][7:0] hdr_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_end;
  } in_t;

  typedef struct packed {
    logic        frame_ok;
    logic [1:0]  error_code;
    logic        is_exception;
    logic [7:0]  exception_code;
    logic        is_response;
    logic [7:0]  slave_address;
    logic [7:0]  function_code;
    logic [15:0] start_address;
    logic [15:0] quantity;
    logic [2:0]  data_offset;
    logic [7:0]  data_length;
    logic [15:0] crc_value;
  } out_t;

  typedef struct packed {
    hdr_t             hdr;
    logic [CNT_W-1:0] count;
    logic             overlong;
    logic             crc_ok;
    logic [15:0]      tail;
  } frame_t;

endpackage

[src/mbrtu_decode.sv]
module mbrtu_decode (
  input  mbrtu_pkg::frame_t frm,
  output mbrtu_pkg::out_t   res
);

  localparam logic [2:0] OFF_REQ    = 3'd2;
  localparam logic [2:0] OFF_RESP   = 3'd3;
  localparam logic [2:0] OFF_SINGLE = 3'd4;
  localparam logic [2:0] OFF_MULTI  = 3'd7;

  mbrtu_pkg::hdr_t h;
  logic [mbrtu_pkg::CNT_W-1:0] n;

  function automatic logic [7:0] clip_len(input logic [8:0] want, input logic [8:0] size,
                                          input logic [2:0] off);
    logic [8:0] off_w;
    logic [8:0] left;
    logic [8:0] m;
    off_w = {6'd0, off};
    left  = (size > off_w) ? size - off_w : 9'd0;
    m     = (want < left) ? want : left;
    return (m > 9'd255) ? 8'hFF : m[7:0];
  endfunction

  assign h = frm.hdr;
  assign n = frm.count;

  always_comb begin
    res = '0;
    if (n < 9'd4) begin
      res.error_code = mbrtu_pkg::ERR_SHORT;
    end else if (frm.overlong) begin
      res.error_code = mbrtu_pkg::ERR_LONG;
    end else if (!frm.crc_ok) begin
      res.error_code = mbrtu_pkg::ERR_CRC;
    end else begin
      res.error_code    = mbrtu_pkg::ERR_NONE;
      res.frame_ok      = 1'b1;
      res.slave_address = h[0];
      res.function_code = h[1];
      if (h[1] >= mbrtu_pkg::FC_EXC_MIN) begin
        res.is_exception   = 1'b1;
        res.exception_code = h[2];
      end else begin
        res.crc_value = {frm.tail[7:0], frm.tail[15:8]};
        unique case (h[1]) inside
          mbrtu_pkg::FC_READ_COILS, mbrtu_pkg::FC_READ_DISCRETE,
          mbrtu_pkg::FC_READ_HOLDING, mbrtu_pkg::FC_READ_INPUT: begin
            if (n == 9'd8) begin
              res.start_address = {h[2], h[3]};
              res.quantity      = {h[4], h[5]};
              res.data_offset   = OFF_REQ;
              res.data_length   = clip_len(9'd4, n, OFF_REQ);
            end else if (n > 9'd4) begin
              res.quantity    = {9'd0, h[2][7:1]};
              res.data_offset = OFF_RESP;
              res.data_length = clip_len({1'b0, h[2]}, n, OFF_RESP);
              res.is_response = 1'b1;
            end
          end
          mbrtu_pkg::FC_WRITE_COIL, mbrtu_pkg::FC_WRITE_REG: begin
            if (n >= 9'd6) begin
              res.start_address = {h[2], h[3]};
              res.data_offset   = OFF_SINGLE;
              res.data_length   = clip_len(9'd2, n, OFF_SINGLE);
            end
          end
          mbrtu_pkg::FC_WRITE_COILS, mbrtu_pkg::FC_WRITE_REGS: begin
            if (n >= 9'd7) begin
              res.start_address = {h[2], h[3]};
              res.quantity      = {h[4], h[5]};
              res.data_offset   = OFF_MULTI;
              res.data_length   = clip_len({1'b0, h[6]}, n, OFF_MULTI);
            end
          end
          default: begin
            res.data_offset = OFF_REQ;
            res.data_length = clip_len(n - 9'd4, n, OFF_REQ);
          end
        endcase
      end
    end
  end

endmodule

[src/modbus_rtu_frame_parser_unit.sv]
// Modbus RTU frame parser.
// Input channel (in_valid, in_stall, in_data): one frame byte per transfer,
// in_data.frame_end set on the last byte of the frame. Bytes are taken at one
// per cycle while in_stall is low; the running CRC-16 (0xA001 reflected,
// start 0xFFFF) is updated on every byte in the same cycle it is taken.
// Result channel (out_valid, out_stall, out_data): one result per frame,
// showing the error outcome or the decoded header, data window and CRC.
// The frame snapshot is captured into the snapshot register, then decoded
// into the output register, which holds the result. Throughput: one byte per
// cycle while in_stall is low, including a new frame directly after a final
// byte.
// A stalled result holds in the output register; one more finished frame can
// wait in the snapshot register, and only then does in_stall rise.
// Bytes past MAX_FRAME_BYTES are not counted and flag the frame as overlong.
// Reset clears byte count, tail bytes, overlong flag and both valid flags and
// sets CRC to 0xFFFF; the header store is not cleared, only read within frame.
module modbus_rtu_frame_parser_unit #(
  parameter int unsigned MAX_FRAME_BYTES = mbrtu_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  mbrtu_pkg::in_t    in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output mbrtu_pkg::out_t   out_data
);

  localparam int unsigned CW = mbrtu_pkg::CNT_W;
  localparam logic [CW-1:0] MAX_CNT  = CW'(MAX_FRAME_BYTES);
  localparam logic [CW-1:0] HDR_CNT  = CW'(mbrtu_pkg::HDR_DEPTH);
  localparam logic [15:0]   CRC_POLY = 16'hA001;
  localparam logic [15:0]   CRC_INIT = 16'hFFFF;

  mbrtu_pkg::hdr_t   hdr_r;
  mbrtu_pkg::hdr_t   hdr_nxt;
  logic [CW-1:0]     cnt_r;
  logic [CW-1:0]     cnt_nxt;
  logic [15:0]       crc_r;
  logic [15:0]       crc_nxt;
  logic [15:0]       tail_r;
  logic [15:0]       tail_nxt;
  logic              ovl_r;
  logic              ovl_nxt;
  logic              cnt_room;

  mbrtu_pkg::frame_t snap_r;
  logic              snap_vld_r;
  logic              snap_vld_nxt;
  mbrtu_pkg::out_t   dec_res;
  mbrtu_pkg::out_t   out_r;
  logic              out_vld_r;
  logic              out_vld_nxt;

  logic              in_acc;
  logic              out_adv;
  logic              frame_done;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  assign out_adv    = !out_vld_r || !out_stall;
  assign in_stall   = snap_vld_r && !out_adv;
  assign in_acc     = in_valid && !in_stall;
  assign frame_done = in_acc && in_data.frame_end;

  always_comb begin
    cnt_room = cnt_r < MAX_CNT;
    hdr_nxt  = hdr_r;
    if (cnt_r < HDR_CNT) begin
      hdr_nxt[cnt_r[mbrtu_pkg::HDR_IDX_W-1:0]] = in_data.rx_byte;
    end
    cnt_nxt  = cnt_room ? cnt_r + CW'(1) : cnt_r;
    ovl_nxt  = ovl_r || !cnt_room;
    crc_nxt  = crc_byte(crc_r, in_data.rx_byte);
    tail_nxt = {tail_r[7:0], in_data.rx_byte};
  end

  assign snap_vld_nxt = (snap_vld_r && !out_adv) || frame_done;
  assign out_vld_nxt  = out_adv ? snap_vld_r : out_vld_r;

  mbrtu_decode u_decode (
    .frm (snap_r),
    .res (dec_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      crc_r      <= CRC_INIT;
      tail_r     <= '0;
      ovl_r      <= 1'b0;
      snap_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      snap_vld_r <= snap_vld_nxt;
      out_vld_r  <= out_vld_nxt;
      if (in_acc) begin
        if (in_data.frame_end) begin
          cnt_r  <= '0;
          crc_r  <= CRC_INIT;
          tail_r <= '0;
          ovl_r  <= 1'b0;
        end else begin
          cnt_r  <= cnt_nxt;
          crc_r  <= crc_nxt;
          tail_r <= tail_nxt;
          ovl_r  <= ovl_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      hdr_r <= hdr_nxt;
    end
    if (frame_done) begin
      snap_r.hdr      <= hdr_nxt;
      snap_r.count    <= cnt_nxt;
      snap_r.overlong <= ovl_nxt;
      snap_r.crc_ok   <= (crc_nxt == 16'd0);
      snap_r.tail     <= tail_nxt;
    end
    if (out_adv && snap_vld_r) begin
      out_r <= dec_res;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule
